@@ hdl/svpwm_pkg.sv @@
// shared types, constants and helper functions of the space vector modulator
package svpwm_pkg;

    // fixed-point constants, Q.16 apart from ONE_Q24, which is Q.24
    localparam logic [15:0]        COS30_U16     = 16'd56756;
    localparam logic signed [17:0] K_COS30       = 18'sd56756;
    localparam logic signed [17:0] K_INV_COS30   = 18'sd75675;
    localparam logic signed [17:0] K_TAN30       = 18'sd37838;
    localparam logic signed [29:0] ONE_Q24       = 30'sd16777216;
    localparam logic [16:0]        MAX_ON_ONE    = 17'h10000;

    // square root chain widths
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int REM_W  = 34;

    // chain lengths of the square root and the two dividers
    localparam int SQRT_STEPS = 32;
    localparam int SCALE_QW   = 32;
    localparam int DUTY_QW    = 27;

    // register indexes
    localparam logic [1:0] REG_PERIOD  = 2'd0;
    localparam logic [1:0] REG_MAX_ON  = 2'd1;
    localparam logic [1:0] REG_REVERSE = 2'd2;

    // sector codes
    localparam logic [2:0] SEC_U_UV = 3'd0;
    localparam logic [2:0] SEC_UV_V = 3'd1;
    localparam logic [2:0] SEC_V_VW = 3'd2;
    localparam logic [2:0] SEC_VW_W = 3'd3;
    localparam logic [2:0] SEC_W_WU = 3'd4;
    localparam logic [2:0] SEC_WU_U = 3'd5;

    // alpha/beta vector with its limit, carried beside the root chain
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic [30:0]        limit;
        logic [15:0]        vdc;
    } svpwm_vec_t;

    // vector and scaling decision, carried beside the scaling divider
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic [15:0]        vdc;
        logic               zero;
        logic               shrink;
    } svpwm_scl_t;

    // sector and signs, carried beside the duty divider
    typedef struct packed {
        logic [2:0] sec;
        logic       neg1;
        logic       neg2;
        logic       fault;
    } svpwm_duty_t;

    // sector from the signs of the three projections
    function automatic logic [2:0] sector_of_signs(input logic [2:0] n);
        logic [2:0] s;
        case (n)
            3'd1:    s = SEC_UV_V;
            3'd2:    s = SEC_WU_U;
            3'd4:    s = SEC_VW_W;
            3'd5:    s = SEC_V_VW;
            3'd6:    s = SEC_W_WU;
            default: s = SEC_U_UV;
        endcase
        return s;
    endfunction

    // rotation into the first sector, cosine part, Q.16
    function automatic logic signed [17:0] rot_cos(input logic [2:0] sec);
        logic signed [17:0] v;
        case (sec)
            SEC_U_UV: v = 18'sd65536;
            SEC_UV_V: v = 18'sd32768;
            SEC_V_VW: v = -18'sd32768;
            SEC_VW_W: v = -18'sd65536;
            SEC_W_WU: v = -18'sd32768;
            default:  v = 18'sd32768;
        endcase
        return v;
    endfunction

    // rotation into the first sector, sine part, Q.16
    function automatic logic signed [17:0] rot_sin(input logic [2:0] sec);
        logic signed [17:0] v;
        case (sec)
            SEC_U_UV: v = 18'sd0;
            SEC_UV_V: v = -18'sd56756;
            SEC_V_VW: v = -18'sd56756;
            SEC_VW_W: v = 18'sd0;
            default:  v = 18'sd56756;
        endcase
        return v;
    endfunction

    // divide by 65536 rounding toward zero
    function automatic logic signed [55:0] div_q16(input logic signed [55:0] v);
        logic signed [55:0] t;
        t = v + (v[55] ? 56'sd65535 : 56'sd0);
        return t >>> 16;
    endfunction

    // magnitude of a 33-bit signed value
    function automatic logic [31:0] abs33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    // clamp a duty to zero..top
    function automatic logic [24:0] clamp_duty(input logic signed [30:0] d,
                                               input logic [24:0] top);
        logic [24:0] r;
        if (d[30]) begin
            r = 25'd0;
        end else if (d > $signed({6'd0, top})) begin
            r = top;
        end else begin
            r = d[24:0];
        end
        return r;
    endfunction

endpackage

@@ hdl/svpwm_sqrt_cell.sv @@
// one digit step of the pipelined integer square root
module svpwm_sqrt_cell (
    input  logic                               aclk,
    input  logic                               en,
    input  logic [svpwm_pkg::RAD_W-1:0]        rad_in,
    input  logic [svpwm_pkg::REM_W-1:0]        rem_in,
    input  logic [svpwm_pkg::ROOT_W-1:0]       root_in,
    output logic [svpwm_pkg::RAD_W-1:0]        rad_reg,
    output logic [svpwm_pkg::REM_W-1:0]        rem_reg,
    output logic [svpwm_pkg::ROOT_W-1:0]       root_reg
);
    localparam int TW = svpwm_pkg::REM_W + 2;

    logic [TW-1:0] cur;
    logic [TW-1:0] trial;
    logic [TW-1:0] diff;
    logic          ge;

    // bring down the next two radicand bits and try the next root bit
    assign cur   = {rem_in, rad_in[svpwm_pkg::RAD_W-1 -: 2]};
    assign trial = TW'({root_in, 2'b01});
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= {rad_in[svpwm_pkg::RAD_W-3:0], 2'b00};
            rem_reg  <= ge ? diff[svpwm_pkg::REM_W-1:0] : cur[svpwm_pkg::REM_W-1:0];
            root_reg <= {root_in[svpwm_pkg::ROOT_W-2:0], ge};
        end
    end
endmodule

@@ hdl/svpwm_div_cell.sv @@
// one quotient bit of a pipelined restoring divider
module svpwm_div_cell #(
    parameter int DIV_W = 16,
    parameter int QUO_W = 16
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DIV_W-1:0] divisor_in,
    input  logic [DIV_W-1:0] rem_in,
    input  logic [QUO_W-1:0] low_in,
    output logic [DIV_W-1:0] divisor_reg,
    output logic [DIV_W-1:0] rem_reg,
    output logic [QUO_W-1:0] low_reg
);
    logic [DIV_W:0] cur;
    logic [DIV_W:0] diff;
    logic           ge;

    // shift in one dividend bit, subtract when it fits
    assign cur  = {rem_in, low_in[QUO_W-1]};
    assign ge   = cur >= {1'b0, divisor_in};
    assign diff = cur - {1'b0, divisor_in};

    always_ff @(posedge aclk) begin
        if (en) begin
            divisor_reg <= divisor_in;
            rem_reg     <= ge ? diff[DIV_W-1:0] : cur[DIV_W-1:0];
            low_reg     <= {low_in[QUO_W-2:0], ge};
        end
    end
endmodule

@@ hdl/space_vector_pwm_modulator.sv @@
// space vector pwm modulator top level: transform, limit, sector, duties, counts
//
// Input channel s_*: one transfer carries sine/cosine of the electrical angle,
// the d/q voltage demands and the bus voltage. Result channel m_*: the three
// compare counts, the sector and the bus fault flag. The cfg_wr_* port writes
// period_count, max_on_fraction and reverse_direction, one register per cycle;
// the user must write them only while no item is in flight, which the block
// itself does not enforce. Throughput is one item per cycle while the
// pipeline is not held. From the input transfer to m_tvalid an item passes
// 4 product stages, a 32-cell square root chain, a scaling setup stage, a
// 32-cell scaling divider, 8 sector and rotation stages, a 27-cell duty
// divider, 3 duty and count stages and the output register.
// Reset clears all valid bits and loads the register defaults; results in
// flight are dropped.
// When the receiver stalls, a one-entry skid register behind the output
// register takes one more result; s_tready drops only while that entry is
// full, and the whole pipeline holds until it drains.
module space_vector_pwm_modulator #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sine_angle, cosine_angle, volt_direct, volt_quadrature, bus_voltage
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // count_u, count_v, count_w, sector_index, zero pad
    output logic [55:0] m_tdata,
    // bus_fault
    output logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [16:0] cfg_wr_data
);
    localparam int SQ_N  = svpwm_pkg::SQRT_STEPS;
    localparam int SC_N  = svpwm_pkg::SCALE_QW;
    localparam int DU_N  = svpwm_pkg::DUTY_QW;
    localparam int TOTAL = 4 + SQ_N + 1 + SC_N + 8 + DU_N + 3;
    localparam logic [15:0] PERIOD_MASK = 16'((17'd1 << COUNT_WIDTH) - 17'd1);

    // configuration registers
    logic [15:0] period_reg;
    logic [16:0] max_on_reg;
    logic        reverse_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= 16'hFFFF;
            max_on_reg  <= svpwm_pkg::MAX_ON_ONE;
            reverse_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                svpwm_pkg::REG_PERIOD:  period_reg  <= cfg_wr_data[15:0];
                svpwm_pkg::REG_MAX_ON:  max_on_reg  <= cfg_wr_data;
                svpwm_pkg::REG_REVERSE: reverse_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    logic [15:0] period_eff;
    logic [16:0] max_cap;
    logic [24:0] duty_top;

    assign period_eff = period_reg & PERIOD_MASK;
    assign max_cap    = max_on_reg[16] ? svpwm_pkg::MAX_ON_ONE : max_on_reg;
    assign duty_top   = {max_cap, 8'd0};

    // pipeline advance and valid chain
    logic             en;
    logic             skid_valid_reg;
    logic [TOTAL-1:0] vld_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-2:0], s_tvalid};
        end
    end

    // input fields
    logic signed [15:0] sin_in, cos_in, vd_in, vq_in;
    logic [15:0]        vdc_in;

    assign sin_in = $signed(s_tdata[15:0]);
    assign cos_in = $signed(s_tdata[31:16]);
    assign vd_in  = $signed(s_tdata[47:32]);
    assign vq_in  = $signed(s_tdata[63:48]);
    assign vdc_in = s_tdata[79:64];

    // stage 1: park products and limit product
    logic signed [31:0] m_dc_reg, m_qs_reg, m_ds_reg, m_qc_reg;
    logic [31:0]        lim_raw_reg;
    logic [15:0]        vdc1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_dc_reg    <= vd_in * cos_in;
            m_qs_reg    <= vq_in * sin_in;
            m_ds_reg    <= vd_in * sin_in;
            m_qc_reg    <= vq_in * cos_in;
            lim_raw_reg <= vdc_in * svpwm_pkg::COS30_U16;
            vdc1_reg    <= vdc_in;
        end
    end

    // stage 2: inverse park sums
    svpwm_pkg::svpwm_vec_t vec2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            vec2_reg.a     <= 33'(m_dc_reg) - 33'(m_qs_reg);
            vec2_reg.b     <= 33'(m_ds_reg) + 33'(m_qc_reg);
            vec2_reg.limit <= lim_raw_reg[31:1];
            vec2_reg.vdc   <= vdc1_reg;
        end
    end

    // stage 3: squares of the components
    logic [63:0]           sq_a3_reg, sq_b3_reg;
    logic [31:0]           ua2, ub2;
    svpwm_pkg::svpwm_vec_t vec3_reg;

    assign ua2 = svpwm_pkg::abs33(vec2_reg.a);
    assign ub2 = svpwm_pkg::abs33(vec2_reg.b);

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_a3_reg <= ua2 * ua2;
            sq_b3_reg <= ub2 * ub2;
            vec3_reg  <= vec2_reg;
        end
    end

    // stage 4: squared magnitude
    logic [63:0]           rad4_reg;
    svpwm_pkg::svpwm_vec_t vec4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            rad4_reg <= sq_a3_reg + sq_b3_reg;
            vec4_reg <= vec3_reg;
        end
    end

    // square root chain
    logic [svpwm_pkg::RAD_W-1:0]  sq_rad  [SQ_N+1];
    logic [svpwm_pkg::REM_W-1:0]  sq_rem  [SQ_N+1];
    logic [svpwm_pkg::ROOT_W-1:0] sq_root [SQ_N+1];
    svpwm_pkg::svpwm_vec_t        sq_side_reg [SQ_N];

    assign sq_rad[0]  = rad4_reg;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
        svpwm_sqrt_cell u_cell (
            .aclk     (aclk),
            .en       (en),
            .rad_in   (sq_rad[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .rad_reg  (sq_rad[i+1]),
            .rem_reg  (sq_rem[i+1]),
            .root_reg (sq_root[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_side_reg[0] <= vec4_reg;
            for (int i = 1; i < SQ_N; i++) begin
                sq_side_reg[i] <= sq_side_reg[i-1];
            end
        end
    end

    // scaling setup: dividends and decision
    svpwm_pkg::svpwm_vec_t vec_sq;
    logic [31:0]           mag;
    logic [31:0]           ua_sq, ub_sq;
    logic [62:0]           dnd_a0_reg, dnd_b0_reg;
    logic [31:0]           mag0_reg;
    svpwm_pkg::svpwm_scl_t scl0_reg;

    assign vec_sq = sq_side_reg[SQ_N-1];
    assign mag    = sq_root[SQ_N];
    assign ua_sq  = svpwm_pkg::abs33(vec_sq.a);
    assign ub_sq  = svpwm_pkg::abs33(vec_sq.b);

    always_ff @(posedge aclk) begin
        if (en) begin
            dnd_a0_reg      <= ua_sq * vec_sq.limit;
            dnd_b0_reg      <= ub_sq * vec_sq.limit;
            mag0_reg        <= mag;
            scl0_reg.a      <= vec_sq.a;
            scl0_reg.b      <= vec_sq.b;
            scl0_reg.vdc    <= vec_sq.vdc;
            scl0_reg.zero   <= mag == 32'd0;
            scl0_reg.shrink <= mag > 32'(vec_sq.limit);
        end
    end

    // scaling divider chain, one lane per component
    logic [31:0]           sc_div_a [SC_N+1];
    logic [31:0]           sc_rem_a [SC_N+1];
    logic [SC_N-1:0]       sc_low_a [SC_N+1];
    logic [31:0]           sc_div_b [SC_N+1];
    logic [31:0]           sc_rem_b [SC_N+1];
    logic [SC_N-1:0]       sc_low_b [SC_N+1];
    svpwm_pkg::svpwm_scl_t sc_side_reg [SC_N];

    assign sc_div_a[0] = mag0_reg;
    assign sc_rem_a[0] = 32'(dnd_a0_reg[62:SC_N]);
    assign sc_low_a[0] = dnd_a0_reg[SC_N-1:0];
    assign sc_div_b[0] = mag0_reg;
    assign sc_rem_b[0] = 32'(dnd_b0_reg[62:SC_N]);
    assign sc_low_b[0] = dnd_b0_reg[SC_N-1:0];

    for (genvar i = 0; i < SC_N; i++) begin : g_scale
        svpwm_div_cell #(.DIV_W(32), .QUO_W(SC_N)) u_cell_a (
            .aclk        (aclk),
            .en          (en),
            .divisor_in  (sc_div_a[i]),
            .rem_in      (sc_rem_a[i]),
            .low_in      (sc_low_a[i]),
            .divisor_reg (sc_div_a[i+1]),
            .rem_reg     (sc_rem_a[i+1]),
            .low_reg     (sc_low_a[i+1])
        );
        svpwm_div_cell #(.DIV_W(32), .QUO_W(SC_N)) u_cell_b (
            .aclk        (aclk),
            .en          (en),
            .divisor_in  (sc_div_b[i]),
            .rem_in      (sc_rem_b[i]),
            .low_in      (sc_low_b[i]),
            .divisor_reg (sc_div_b[i+1]),
            .rem_reg     (sc_rem_b[i+1]),
            .low_reg     (sc_low_b[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_side_reg[0] <= scl0_reg;
            for (int i = 1; i < SC_N; i++) begin
                sc_side_reg[i] <= sc_side_reg[i-1];
            end
        end
    end

    // limited vector
    svpwm_pkg::svpwm_scl_t scl_end;
    logic signed [32:0]    qa_s, qb_s, a_lim, b_lim;
    logic signed [32:0]    a5_reg, b5_reg;
    logic [15:0]           vdc5_reg;

    assign scl_end = sc_side_reg[SC_N-1];
    assign qa_s    = $signed({1'b0, sc_low_a[SC_N]});
    assign qb_s    = $signed({1'b0, sc_low_b[SC_N]});

    always_comb begin
        if (scl_end.zero) begin
            a_lim = '0;
            b_lim = '0;
        end else if (scl_end.shrink) begin
            a_lim = scl_end.a[32] ? -qa_s : qa_s;
            b_lim = scl_end.b[32] ? -qb_s : qb_s;
        end else begin
            a_lim = scl_end.a;
            b_lim = scl_end.b;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a5_reg   <= a_lim;
            b5_reg   <= b_lim;
            vdc5_reg <= scl_end.vdc;
        end
    end

    // projection product
    logic signed [49:0] ka6_reg;
    logic signed [32:0] a6_reg, b6_reg;
    logic [15:0]        vdc6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ka6_reg  <= a5_reg * svpwm_pkg::K_COS30;
            a6_reg   <= a5_reg;
            b6_reg   <= b5_reg;
            vdc6_reg <= vdc5_reg;
        end
    end

    // sector from projection signs
    logic signed [49:0] bsh, p2, p3;
    logic [2:0]         sgn;
    logic [2:0]         sec7_reg;
    logic signed [32:0] a7_reg, b7_reg;
    logic [15:0]        vdc7_reg;

    assign bsh = 50'(b6_reg) <<< 15;
    assign p2  = ka6_reg - bsh;
    assign p3  = -ka6_reg - bsh;
    assign sgn = {p3 > 50'sd0, p2 > 50'sd0, b6_reg > 33'sd0};

    always_ff @(posedge aclk) begin
        if (en) begin
            sec7_reg <= svpwm_pkg::sector_of_signs(sgn);
            a7_reg   <= a6_reg;
            b7_reg   <= b6_reg;
            vdc7_reg <= vdc6_reg;
        end
    end

    // rotation products
    logic signed [17:0] rc, rs;
    logic signed [50:0] m_ac8_reg, m_bs8_reg, m_as8_reg, m_bc8_reg;
    logic [2:0]         sec8_reg;
    logic [15:0]        vdc8_reg;

    assign rc = svpwm_pkg::rot_cos(sec7_reg);
    assign rs = svpwm_pkg::rot_sin(sec7_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_ac8_reg <= a7_reg * rc;
            m_bs8_reg <= b7_reg * rs;
            m_as8_reg <= a7_reg * rs;
            m_bc8_reg <= b7_reg * rc;
            sec8_reg  <= sec7_reg;
            vdc8_reg  <= vdc7_reg;
        end
    end

    // rotated components, truncated toward zero
    logic signed [51:0] xs, ys;
    logic signed [55:0] xq, yq;
    logic signed [33:0] x9_reg, y9_reg;
    logic [2:0]         sec9_reg;
    logic [15:0]        vdc9_reg;

    assign xs = 52'(m_ac8_reg) - 52'(m_bs8_reg);
    assign ys = 52'(m_as8_reg) + 52'(m_bc8_reg);
    assign xq = svpwm_pkg::div_q16(56'(xs));
    assign yq = svpwm_pkg::div_q16(56'(ys));

    always_ff @(posedge aclk) begin
        if (en) begin
            x9_reg   <= xq[33:0];
            y9_reg   <= yq[33:0];
            sec9_reg <= sec8_reg;
            vdc9_reg <= vdc8_reg;
        end
    end

    // active vector products
    logic signed [51:0] my1_10_reg, my2_10_reg;
    logic signed [33:0] x10_reg;
    logic [2:0]         sec10_reg;
    logic [15:0]        vdc10_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            my1_10_reg <= y9_reg * svpwm_pkg::K_INV_COS30;
            my2_10_reg <= y9_reg * svpwm_pkg::K_TAN30;
            x10_reg    <= x9_reg;
            sec10_reg  <= sec9_reg;
            vdc10_reg  <= vdc9_reg;
        end
    end

    // active vector lengths
    logic signed [55:0] v2q, tq;
    logic signed [34:0] v1_11_reg, v2_11_reg;
    logic [2:0]         sec11_reg;
    logic [15:0]        vdc11_reg;

    assign v2q = svpwm_pkg::div_q16(56'(my1_10_reg));
    assign tq  = svpwm_pkg::div_q16(56'(my2_10_reg));

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_11_reg <= 35'(x10_reg) - tq[34:0];
            v2_11_reg <= v2q[34:0];
            sec11_reg <= sec10_reg;
            vdc11_reg <= vdc10_reg;
        end
    end

    // duty dividends
    logic signed [34:0]     nv1, nv2;
    logic [33:0]            av1, av2;
    logic [42:0]            dv1_12_reg, dv2_12_reg;
    logic [15:0]            vdc12_reg;
    svpwm_pkg::svpwm_duty_t du12_reg;

    assign nv1 = -v1_11_reg;
    assign nv2 = -v2_11_reg;
    assign av1 = v1_11_reg[34] ? nv1[33:0] : v1_11_reg[33:0];
    assign av2 = v2_11_reg[34] ? nv2[33:0] : v2_11_reg[33:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dv1_12_reg     <= {av1, 9'd0};
            dv2_12_reg     <= {av2, 9'd0};
            vdc12_reg      <= vdc11_reg;
            du12_reg.sec   <= sec11_reg;
            du12_reg.neg1  <= v1_11_reg[34];
            du12_reg.neg2  <= v2_11_reg[34];
            du12_reg.fault <= vdc11_reg == 16'd0;
        end
    end

    // duty divider chain, one lane per active vector
    logic [15:0]            du_div_1 [DU_N+1];
    logic [15:0]            du_rem_1 [DU_N+1];
    logic [DU_N-1:0]        du_low_1 [DU_N+1];
    logic [15:0]            du_div_2 [DU_N+1];
    logic [15:0]            du_rem_2 [DU_N+1];
    logic [DU_N-1:0]        du_low_2 [DU_N+1];
    svpwm_pkg::svpwm_duty_t du_side_reg [DU_N];

    assign du_div_1[0] = vdc12_reg;
    assign du_rem_1[0] = 16'(dv1_12_reg[42:DU_N]);
    assign du_low_1[0] = dv1_12_reg[DU_N-1:0];
    assign du_div_2[0] = vdc12_reg;
    assign du_rem_2[0] = 16'(dv2_12_reg[42:DU_N]);
    assign du_low_2[0] = dv2_12_reg[DU_N-1:0];

    for (genvar i = 0; i < DU_N; i++) begin : g_duty
        svpwm_div_cell #(.DIV_W(16), .QUO_W(DU_N)) u_cell_1 (
            .aclk        (aclk),
            .en          (en),
            .divisor_in  (du_div_1[i]),
            .rem_in      (du_rem_1[i]),
            .low_in      (du_low_1[i]),
            .divisor_reg (du_div_1[i+1]),
            .rem_reg     (du_rem_1[i+1]),
            .low_reg     (du_low_1[i+1])
        );
        svpwm_div_cell #(.DIV_W(16), .QUO_W(DU_N)) u_cell_2 (
            .aclk        (aclk),
            .en          (en),
            .divisor_in  (du_div_2[i]),
            .rem_in      (du_rem_2[i]),
            .low_in      (du_low_2[i]),
            .divisor_reg (du_div_2[i+1]),
            .rem_reg     (du_rem_2[i+1]),
            .low_reg     (du_low_2[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            du_side_reg[0] <= du12_reg;
            for (int i = 1; i < DU_N; i++) begin
                du_side_reg[i] <= du_side_reg[i-1];
            end
        end
    end

    // signed active duties and zero duty
    svpwm_pkg::svpwm_duty_t du_end;
    logic signed [DU_N:0]   q1_s, q2_s, d1, d2;
    logic signed [29:0]     zt, dz;
    logic signed [DU_N:0]   d1_13_reg, d2_13_reg;
    logic signed [29:0]     dz13_reg;
    logic [2:0]             sec13_reg;
    logic                   fault13_reg;

    assign du_end = du_side_reg[DU_N-1];
    assign q1_s   = $signed({1'b0, du_low_1[DU_N]});
    assign q2_s   = $signed({1'b0, du_low_2[DU_N]});
    assign d1     = du_end.neg1 ? -q1_s : q1_s;
    assign d2     = du_end.neg2 ? -q2_s : q2_s;
    assign zt     = svpwm_pkg::ONE_Q24 - 30'(d1) - 30'(d2);
    assign dz     = (zt + (zt[29] ? 30'sd1 : 30'sd0)) >>> 1;

    always_ff @(posedge aclk) begin
        if (en) begin
            d1_13_reg   <= d1;
            d2_13_reg   <= d2;
            dz13_reg    <= dz;
            sec13_reg   <= du_end.sec;
            fault13_reg <= du_end.fault;
        end
    end

    // phase duties by sector, clamp and swap
    logic signed [30:0] s_z, s_1, s_2, s_12;
    logic signed [30:0] du_raw, dv_raw, dw_raw;
    logic [24:0]        du_c, dv_c, dw_c;
    logic [24:0]        du14_reg, dv14_reg, dw14_reg;
    logic [2:0]         sec14_reg;
    logic               fault14_reg;

    assign s_z  = 31'(dz13_reg);
    assign s_1  = s_z + 31'(d1_13_reg);
    assign s_2  = s_z + 31'(d2_13_reg);
    assign s_12 = s_1 + 31'(d2_13_reg);

    always_comb begin
        case (sec13_reg)
            svpwm_pkg::SEC_U_UV: begin
                du_raw = s_12; dv_raw = s_2;  dw_raw = s_z;
            end
            svpwm_pkg::SEC_UV_V: begin
                du_raw = s_1;  dv_raw = s_12; dw_raw = s_z;
            end
            svpwm_pkg::SEC_V_VW: begin
                du_raw = s_z;  dv_raw = s_12; dw_raw = s_2;
            end
            svpwm_pkg::SEC_VW_W: begin
                du_raw = s_z;  dv_raw = s_1;  dw_raw = s_12;
            end
            svpwm_pkg::SEC_W_WU: begin
                du_raw = s_2;  dv_raw = s_z;  dw_raw = s_12;
            end
            default: begin
                du_raw = s_12; dv_raw = s_z;  dw_raw = s_1;
            end
        endcase
    end

    assign du_c = svpwm_pkg::clamp_duty(du_raw, duty_top);
    assign dv_c = svpwm_pkg::clamp_duty(dv_raw, duty_top);
    assign dw_c = svpwm_pkg::clamp_duty(dw_raw, duty_top);

    always_ff @(posedge aclk) begin
        if (en) begin
            du14_reg    <= du_c;
            dv14_reg    <= reverse_reg ? dw_c : dv_c;
            dw14_reg    <= reverse_reg ? dv_c : dw_c;
            sec14_reg   <= sec13_reg;
            fault14_reg <= fault13_reg;
        end
    end

    // duty times period
    logic [40:0] pu15_reg, pv15_reg, pw15_reg;
    logic [2:0]  sec15_reg;
    logic        fault15_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pu15_reg    <= du14_reg * period_eff;
            pv15_reg    <= dv14_reg * period_eff;
            pw15_reg    <= dw14_reg * period_eff;
            sec15_reg   <= sec14_reg;
            fault15_reg <= fault14_reg;
        end
    end

    // final counts
    logic [15:0] cu, cv, cw;
    logic [55:0] res_data;

    assign cu       = fault15_reg ? 16'd0 : pu15_reg[39:24];
    assign cv       = fault15_reg ? 16'd0 : pv15_reg[39:24];
    assign cw       = fault15_reg ? 16'd0 : pw15_reg[39:24];
    assign res_data = {5'd0, sec15_reg, cw, cv, cu};

    // output register with skid entry
    logic        out_valid_reg;
    logic [55:0] out_data_reg;
    logic        out_fault_reg;
    logic [55:0] skid_data_reg;
    logic        skid_fault_reg;
    logic        res_valid;
    logic        out_fire;

    assign res_valid = vld_reg[TOTAL-1];
    assign out_fire  = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (out_fire) begin
                out_data_reg   <= skid_data_reg;
                out_fault_reg  <= skid_fault_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (res_valid) begin
            if (!out_valid_reg || out_fire) begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= res_data;
                out_fault_reg <= fault15_reg;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res_data;
                skid_fault_reg <= fault15_reg;
            end
        end else if (out_fire) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_fault_reg;

    // skid entry only holds data behind a waiting output
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full without a pending output");

    // skid entry fills only after the receiver stalled a pending output
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without a stall");

    // a bus fault forces all counts to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[47:0] == 48'd0))
        else $error("counts not zero on bus fault");

    // sector code stays within the six sectors
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[50:48] <= svpwm_pkg::SEC_WU_U))
        else $error("sector out of range");
endmodule
